### design/msq_pkg.sv
// Shared constants and controller/datapath interface types for the square-count block.
`default_nettype none

package msq_pkg;

	// Field widths fixed by the interface.
	localparam int TARGET_W = 12;
	localparam int COUNT_W  = 3;

	// Default number of table entries.
	localparam int MAX_N_DEFAULT = 4096;

	// Answer given for a target that does not fit in the table.
	localparam logic [COUNT_W-1:0] OUT_OF_RANGE = 3'd7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;         // capture the request and preset the first entry
		logic wr_zero;      // write entry 0 with zero
		logic scan;         // read one candidate entry and step the square
		logic write_entry;  // store the finished entry
		logic advance;      // move on to the next entry
		logic set_result;   // load the result register
	} msq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_range;     // target fits in the table
		logic target_zero;  // target is zero
		logic sq_le_i;      // current square does not exceed the entry index
		logic i_eq_target;  // current entry is the target
	} msq_sts_t;

endpackage

`default_nettype wire

### design/min_square_sum_count_core.sv
// Top level of the fewest-perfect-squares block: controller plus datapath.
//
//   Channel  Signals                          Direction
//   in       in_valid, in_ready, target_value  request in
//   out      out_valid, out_ready, square_count result out
//
// One request at a time. A request for target T occupies the block while the table
// is filled for every entry from 1 to T, paced by the single read port of the table
// memory: one candidate entry is read per cycle. T = 0 or an out-of-range target skips
// the fill and goes straight to the result.
// arst_n clears the controller only; the table needs no clearing pass.
// A stalled result holds in its register while the next request is accepted;
// the next result then waits in the last step until the stalled one is taken.
`default_nettype none

module min_square_sum_count_core
	import msq_pkg::*;
#(
	parameter int MAX_N = MAX_N_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [TARGET_W-1:0] target_value,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [COUNT_W-1:0]  square_count
);

	msq_cmd_t cmd;
	msq_sts_t sts;

	msq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	msq_datapath #(
		.MAX_N (MAX_N)
	) u_dp (
		.clk          (clk),
		.target_value (target_value),
		.cmd          (cmd),
		.sts          (sts),
		.square_count (square_count)
	);

endmodule

`default_nettype wire

### design/msq_datapath.sv
// Datapath: scratch table memory, entry and square counters, running minimum and result.
`default_nettype none

module msq_datapath
	import msq_pkg::*;
#(
	parameter int MAX_N = MAX_N_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic [TARGET_W-1:0] target_value,
	input  wire msq_cmd_t            cmd,
	output msq_sts_t                 sts,
	output logic      [COUNT_W-1:0]  square_count
);

	localparam int IW = $clog2(MAX_N);
	// The square runs past the largest index, so it gets two bits of headroom.
	localparam int SW = IW + 2;

	logic [TARGET_W-1:0] target_q;
	logic [IW-1:0]       i_q;
	logic [SW-1:0]       sq_q;
	logic [SW-1:0]       odd_q;
	logic [COUNT_W-1:0]  best_q;
	logic [COUNT_W-1:0]  res_q;
	logic [COUNT_W-1:0]  rd_s1;
	logic                rd_vld_s1;

	logic [COUNT_W-1:0]  mem [MAX_N];

	logic [IW-1:0]       raddr;
	logic [IW-1:0]       waddr;
	logic [COUNT_W-1:0]  wdata;
	logic                wen;
	logic [IW:0]         i_nxt;
	logic [COUNT_W-1:0]  best_init;
	logic [COUNT_W:0]    cand;

	// Status toward the controller.
	assign sts.in_range    = 32'(target_q) < 32'(MAX_N);
	assign sts.target_zero = (target_q == '0);
	assign sts.sq_le_i     = (sq_q <= {2'b0, i_q});
	assign sts.i_eq_target = (32'(i_q) == 32'(target_q));

	// Address of the entry that lies one square below the current index.
	assign raddr = IW'({2'b0, i_q} - sq_q);

	// Single write port: entry 0 at the start of a request, else the current entry.
	assign wen   = cmd.wr_zero | cmd.write_entry;
	assign waddr = cmd.wr_zero ? '0 : i_q;
	assign wdata = cmd.wr_zero ? '0 : best_q;

	// Starting value of the next entry is its index, saturated to the count width.
	assign i_nxt     = {1'b0, i_q} + 1'b1;
	assign best_init = (32'(i_nxt) >= 32'd7) ? 3'd7 : COUNT_W'(i_nxt);

	// Candidate from the entry read in the previous cycle.
	assign cand = {1'b0, rd_s1} + 1'b1;

	// Table memory with registered read data.
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[raddr];
	end

	// Index, square, running minimum and result registers.
	always_ff @(posedge clk) begin
		rd_vld_s1 <= cmd.scan;
		if (rd_vld_s1 && (cand < {1'b0, best_q})) begin
			best_q <= cand[COUNT_W-1:0];
		end
		if (cmd.scan) begin
			sq_q  <= sq_q + odd_q;
			odd_q <= odd_q + SW'(2);
		end
		if (cmd.load) begin
			target_q <= target_value;
			i_q      <= IW'(1);
			sq_q     <= SW'(1);
			odd_q    <= SW'(3);
			best_q   <= COUNT_W'(1);
		end else if (cmd.advance) begin
			i_q    <= i_nxt[IW-1:0];
			sq_q   <= SW'(1);
			odd_q  <= SW'(3);
			best_q <= best_init;
		end
		if (cmd.set_result) begin
			if (!sts.in_range) begin
				res_q <= OUT_OF_RANGE;
			end else if (sts.target_zero) begin
				res_q <= '0;
			end else begin
				res_q <= best_q;
			end
		end
	end

	assign square_count = res_q;

endmodule

`default_nettype wire

### design/msq_ctrl.sv
// Controller: sequences the table fill for one request and owns the handshakes.
`default_nettype none

module msq_ctrl
	import msq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire msq_sts_t sts,
	output msq_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_WRITE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   res_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid & in_ready;
	assign res_free  = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;

	// Commands decoded from the current state and datapath status.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = accept;
			end
			ST_CHECK: begin
				cmd.wr_zero = sts.in_range & ~sts.target_zero;
			end
			ST_SCAN: begin
				cmd.scan = sts.sq_le_i;
			end
			ST_WRITE: begin
				cmd.write_entry = 1'b1;
				cmd.advance     = ~sts.i_eq_target;
			end
			ST_FINISH: begin
				cmd.set_result = res_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and result-valid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.set_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!sts.in_range || sts.target_zero) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!sts.sq_le_i) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (sts.i_eq_target) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_FINISH: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### design/msq_checker.sv
// Port-level checker for the square-count block and its bind to the top level.
`default_nettype none

module msq_checker
	import msq_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic [TARGET_W-1:0] target_value,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [COUNT_W-1:0]  square_count
);

	// A pending request holds until accepted.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(target_value))
		else $error("request dropped or changed while stalled");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(square_count))
		else $error("result dropped or changed while stalled");

	// Four squares always suffice; seven marks an out-of-range target.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> square_count <= 3'd4 || square_count == OUT_OF_RANGE)
		else $error("result outside the possible answers");

	// The block works on one request at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

endmodule

bind min_square_sum_count_core msq_checker u_msq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.target_value (target_value),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.square_count (square_count)
);

`default_nettype wire
